>>> hw/rtl/ppc_pkg.sv
// Types and constants shared by the polygon plane clipper.
package ppc_pkg;

    typedef logic [31:0] coord_t;
    typedef logic [47:0] dot_t;

    localparam int NUM_COORDS = 5;
    localparam int NUM_NORMALS = 3;

    localparam logic [1:0] CFG_NORMAL_X   = 2'd0;
    localparam logic [1:0] CFG_NORMAL_Y   = 2'd1;
    localparam logic [1:0] CFG_NORMAL_Z   = 2'd2;
    localparam logic [1:0] CFG_PLANE_DIST = 2'd3;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_END    = 1'b1;

    localparam logic [15:0] NORMAL_Z_RESET   = 16'sd16384;
    localparam logic [31:0] PLANE_DIST_RESET = 32'hFFFF_0000;
    localparam logic [16:0] SCALE_ONE        = 17'h10000;
    localparam logic [7:0]  MIN_ACCEPTED     = 8'd3;

endpackage

>>> hw/rtl/polygon_plane_clipper.sv
// Top level of the single-plane Sutherland-Hodgman polygon clipper.
//
// One vertex beat enters when the block is idle; the block then works on it alone and drops
// s_tready until every result beat of that vertex is taken. A shared 33x18 signed multiplier
// forms the plane dot product. Each edge then passes the bookkeeping states EDGE_A, EDGE_X and
// EDGE_END, and an edge that crosses the plane adds a check state, a restoring divider for
// the Q1.16 scale (skipped when the ratio clamps to 0 or 1) and multiply-add interpolation.
// The first vertex of an open polygon only forms and stores its dot product; the final vertex
// also handles the closing edge back to the first vertex. Each result beat may stall on m_tready.
// Configuration writes are always ready and must arrive while idle.
module polygon_plane_clipper #(
    parameter int MAX_OUT_VERTICES = 128
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic         s_tlast,   // final_vertex
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // out_x, out_y, out_z, out_u, out_v, vertex_count
    output logic [1:0]   m_tuser,   // kind, accepted
    output logic         m_tlast,   // out_last
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import ppc_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DOT      = 4'd1;
    localparam logic [3:0] ST_DOT_END  = 4'd2;
    localparam logic [3:0] ST_EDGE_A   = 4'd3;
    localparam logic [3:0] ST_EDGE_X   = 4'd4;
    localparam logic [3:0] ST_DIV_CHK  = 4'd5;
    localparam logic [3:0] ST_DIV      = 4'd6;
    localparam logic [3:0] ST_IMUL     = 4'd7;
    localparam logic [3:0] ST_IADD     = 4'd8;
    localparam logic [3:0] ST_EDGE_END = 4'd9;
    localparam logic [3:0] ST_WAIT     = 4'd10;

    localparam logic [7:0] COUNT_MAX = 8'(MAX_OUT_VERTICES);

    logic [3:0]  state_reg, state_next, ret_reg, ret_next;
    logic [15:0] normal_reg [NUM_NORMALS];
    logic [31:0] dist_reg;

    coord_t cur_reg [NUM_COORDS], cur_next [NUM_COORDS];
    coord_t prev_reg [NUM_COORDS], prev_next [NUM_COORDS];
    coord_t first_reg [NUM_COORDS], first_next [NUM_COORDS];
    coord_t xp_reg [NUM_COORDS], xp_next [NUM_COORDS];
    coord_t out_vert_reg [NUM_COORDS], out_vert_next [NUM_COORDS];
    coord_t a_vec [NUM_COORDS], b_vec [NUM_COORDS];

    dot_t cur_dot_reg, cur_dot_next, prev_dot_reg, prev_dot_next;
    dot_t first_dot_reg, first_dot_next, da, db;
    logic cur_ins_reg, cur_ins_next, prev_ins_reg, prev_ins_next;
    logic first_ins_reg, first_ins_next, ia, ib;
    logic have_first_reg, have_first_next, fin_reg, fin_next;
    logic edge_sel_reg, edge_sel_next;
    logic [7:0] count_reg, count_next;
    logic [2:0] idx_reg, idx_next;
    logic [3:0] div_cnt_reg, div_cnt_next;
    logic [50:0] prod_reg, prod_next, acc_reg, acc_next;
    logic [48:0] rem_reg, rem_next, den_reg, den_next;
    logic ratio_ok_reg, ratio_ok_next;
    logic [16:0] scale_reg, scale_next;

    logic m_valid_reg, m_valid_next, out_kind_reg, out_kind_next;
    logic out_last_reg, out_last_next, out_acc_reg, out_acc_next;
    logic [7:0] out_cnt_reg, out_cnt_next;

    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;
    logic signed [48:0] num_w, den_w;
    logic [49:0] rem2;
    logic div_ge;
    dot_t dot_w;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = {out_acc_reg, out_kind_reg};
    assign m_tdata   = {out_cnt_reg, out_vert_reg[4], out_vert_reg[3], out_vert_reg[2],
                        out_vert_reg[1], out_vert_reg[0]};

    always_comb begin
        for (int j = 0; j < NUM_COORDS; j++) begin
            a_vec[j] = edge_sel_reg ? cur_reg[j] : prev_reg[j];
            b_vec[j] = edge_sel_reg ? first_reg[j] : cur_reg[j];
        end
        da = edge_sel_reg ? cur_dot_reg : prev_dot_reg;
        db = edge_sel_reg ? first_dot_reg : cur_dot_reg;
        ia = edge_sel_reg ? cur_ins_reg : prev_ins_reg;
        ib = edge_sel_reg ? first_ins_reg : cur_ins_reg;
    end

    always_comb begin
        if (state_reg == ST_IMUL) begin
            mul_a = $signed({b_vec[idx_reg][31], b_vec[idx_reg]})
                  - $signed({a_vec[idx_reg][31], a_vec[idx_reg]});
            mul_b = $signed({1'b0, scale_reg});
        end else begin
            mul_a = $signed({cur_reg[idx_reg][31], cur_reg[idx_reg]});
            unique case (idx_reg)
                3'd0:    mul_b = $signed({{2{normal_reg[0][15]}}, normal_reg[0]});
                3'd1:    mul_b = $signed({{2{normal_reg[1][15]}}, normal_reg[1]});
                3'd2:    mul_b = $signed({{2{normal_reg[2][15]}}, normal_reg[2]});
                default: mul_b = '0;
            endcase
        end
        mul_p  = mul_a * mul_b;
        dot_w  = 48'($signed(acc_reg) >>> 14);
        num_w  = $signed({{17{dist_reg[31]}}, dist_reg}) - $signed({da[47], da});
        den_w  = $signed({db[47], db}) - $signed({da[47], da});
        rem2   = {rem_reg, 1'b0};
        div_ge = (rem2 >= {1'b0, den_reg});
    end

    always_comb begin
        state_next = state_reg;   ret_next = ret_reg;
        cur_next = cur_reg;       prev_next = prev_reg;
        first_next = first_reg;   xp_next = xp_reg;
        out_vert_next = out_vert_reg;
        cur_dot_next = cur_dot_reg;     prev_dot_next = prev_dot_reg;
        first_dot_next = first_dot_reg;
        cur_ins_next = cur_ins_reg;     prev_ins_next = prev_ins_reg;
        first_ins_next = first_ins_reg;
        have_first_next = have_first_reg;
        fin_next = fin_reg;       edge_sel_next = edge_sel_reg;
        count_next = count_reg;   idx_next = idx_reg;
        div_cnt_next = div_cnt_reg;
        prod_next = prod_reg;     acc_next = acc_reg;
        rem_next = rem_reg;       den_next = den_reg;
        ratio_ok_next = ratio_ok_reg;   scale_next = scale_reg;
        m_valid_next = m_valid_reg;     out_kind_next = out_kind_reg;
        out_last_next = out_last_reg;   out_acc_next = out_acc_reg;
        out_cnt_next = out_cnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    for (int j = 0; j < NUM_COORDS; j++) begin
                        cur_next[j] = s_tdata[32*j +: 32];
                    end
                    fin_next   = s_tlast;
                    acc_next   = '0;
                    idx_next   = '0;
                    state_next = ST_DOT;
                end
            end
            ST_DOT: begin
                prod_next = 51'(mul_p);
                if (idx_reg != 3'd0) begin
                    acc_next = acc_reg + prod_reg;
                end
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd3) begin
                    state_next = ST_DOT_END;
                end
            end
            ST_DOT_END: begin
                cur_dot_next = dot_w;
                cur_ins_next = ($signed(dot_w) >= $signed({{16{dist_reg[31]}}, dist_reg}));
                if (!have_first_reg) begin
                    first_next      = cur_reg;
                    prev_next       = cur_reg;
                    first_dot_next  = dot_w;
                    prev_dot_next   = dot_w;
                    first_ins_next  = cur_ins_next;
                    prev_ins_next   = cur_ins_next;
                    have_first_next = 1'b1;
                    edge_sel_next   = 1'b1;
                    state_next      = fin_reg ? ST_EDGE_A : ST_IDLE;
                end else begin
                    edge_sel_next = 1'b0;
                    state_next    = ST_EDGE_A;
                end
            end
            ST_EDGE_A: begin
                state_next = ST_EDGE_X;
                if (ia) begin
                    out_vert_next = a_vec;
                    out_kind_next = KIND_VERTEX;
                    out_acc_next  = 1'b0;
                    out_cnt_next  = '0;
                    out_last_next = !edge_sel_reg && !fin_reg && (ia == ib);
                    m_valid_next  = 1'b1;
                    if (count_reg < COUNT_MAX) begin
                        count_next = count_reg + 8'd1;
                    end
                    ret_next   = ST_EDGE_X;
                    state_next = ST_WAIT;
                end
            end
            ST_EDGE_X: begin
                rem_next      = num_w[48] ? 49'(-num_w) : 49'(num_w);
                den_next      = den_w[48] ? 49'(-den_w) : 49'(den_w);
                ratio_ok_next = (den_w != '0) && (num_w != '0) && (num_w[48] == den_w[48]);
                state_next    = (ia != ib) ? ST_DIV_CHK : ST_EDGE_END;
            end
            ST_DIV_CHK: begin
                idx_next     = '0;
                div_cnt_next = '0;
                scale_next   = '0;
                if (!ratio_ok_reg) begin
                    state_next = ST_IMUL;
                end else if (rem_reg >= den_reg) begin
                    scale_next = SCALE_ONE;
                    state_next = ST_IMUL;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next     = div_ge ? 49'(rem2 - {1'b0, den_reg}) : 49'(rem2);
                scale_next   = {1'b0, scale_reg[14:0], div_ge};
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'd15) begin
                    state_next = ST_IMUL;
                end
            end
            ST_IMUL: begin
                prod_next  = 51'(mul_p);
                state_next = ST_IADD;
            end
            ST_IADD: begin
                xp_next[idx_reg] = a_vec[idx_reg] + prod_reg[47:16];
                idx_next   = idx_reg + 3'd1;
                state_next = ST_IMUL;
                if (idx_reg == 3'(NUM_COORDS - 1)) begin
                    out_vert_next = xp_next;
                    out_kind_next = KIND_VERTEX;
                    out_acc_next  = 1'b0;
                    out_cnt_next  = '0;
                    out_last_next = !edge_sel_reg && !fin_reg;
                    m_valid_next  = 1'b1;
                    if (count_reg < COUNT_MAX) begin
                        count_next = count_reg + 8'd1;
                    end
                    ret_next   = ST_EDGE_END;
                    state_next = ST_WAIT;
                end
            end
            ST_EDGE_END: begin
                if (!edge_sel_reg) begin
                    prev_next     = cur_reg;
                    prev_dot_next = cur_dot_reg;
                    prev_ins_next = cur_ins_reg;
                    edge_sel_next = 1'b1;
                    state_next    = fin_reg ? ST_EDGE_A : ST_IDLE;
                end else begin
                    for (int j = 0; j < NUM_COORDS; j++) begin
                        out_vert_next[j] = '0;
                    end
                    out_kind_next   = KIND_END;
                    out_acc_next    = (count_reg >= MIN_ACCEPTED);
                    out_cnt_next    = count_reg;
                    out_last_next   = 1'b1;
                    m_valid_next    = 1'b1;
                    have_first_next = 1'b0;
                    count_next      = '0;
                    ret_next        = ST_IDLE;
                    state_next      = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    state_next   = ret_reg;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            have_first_reg <= 1'b0;
            count_reg      <= '0;
            edge_sel_reg   <= 1'b0;
            fin_reg        <= 1'b0;
            normal_reg[0]  <= '0;
            normal_reg[1]  <= '0;
            normal_reg[2]  <= NORMAL_Z_RESET;
            dist_reg       <= PLANE_DIST_RESET;
            prev_dot_reg   <= '0;
            first_dot_reg  <= '0;
            prev_ins_reg   <= 1'b0;
            first_ins_reg  <= 1'b0;
            for (int j = 0; j < NUM_COORDS; j++) begin
                prev_reg[j]  <= '0;
                first_reg[j] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            m_valid_reg    <= m_valid_next;
            have_first_reg <= have_first_next;
            count_reg      <= count_next;
            edge_sel_reg   <= edge_sel_next;
            fin_reg        <= fin_next;
            prev_dot_reg   <= prev_dot_next;
            first_dot_reg  <= first_dot_next;
            prev_ins_reg   <= prev_ins_next;
            first_ins_reg  <= first_ins_next;
            prev_reg       <= prev_next;
            first_reg      <= first_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_NORMAL_X:   normal_reg[0] <= cfg_data[15:0];
                    CFG_NORMAL_Y:   normal_reg[1] <= cfg_data[15:0];
                    CFG_NORMAL_Z:   normal_reg[2] <= cfg_data[15:0];
                    CFG_PLANE_DIST: dist_reg      <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        xp_reg        <= xp_next;
        out_vert_reg  <= out_vert_next;
        cur_dot_reg   <= cur_dot_next;
        cur_ins_reg   <= cur_ins_next;
        idx_reg       <= idx_next;
        div_cnt_reg   <= div_cnt_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        ratio_ok_reg  <= ratio_ok_next;
        scale_reg     <= scale_next;
        out_kind_reg  <= out_kind_next;
        out_last_reg  <= out_last_next;
        out_acc_reg   <= out_acc_next;
        out_cnt_reg   <= out_cnt_next;
    end

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result beat is pending");

    a_marker_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("end marker beat without tlast");

    a_div_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_MAX)
        else $error("vertex count above saturation limit");

endmodule
